// ===== rtl/core/caf_pkg.sv =====
// shared types and constants for the can receive acceptance filter
package caf_pkg;

  localparam int CFG_W  = 6;
  localparam int EIDX_W = 6;
  localparam int ID_W   = 11;
  localparam int KEY_W  = 12;
  localparam int MIDX_W = 5;
  localparam int CMP_W  = 7;
  localparam int ENT_W  = KEY_W + ID_W;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 6'd32;
  localparam logic [KEY_W-1:0] FULL_MASK    = 12'hFFF;

  localparam logic MODE_PROGRAM = 1'b0;
  localparam logic MODE_RECEIVE = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ILL_ARG = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic              status;
    logic              matched;
    logic              delivered;
    logic [MIDX_W-1:0] idx;
  } res_t;

endpackage

// ===== rtl/core/caf_ram.sv =====
// generic single write port ram with registered read
module caf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/can_rx_acceptance_filter_top.sv =====
// can receive acceptance filter bank, one entry compared per cycle
//
//   channel | dir | beat
//   cfg     | in  | cfg_data: active entry count
//   in      | in  | mode, entry_index, msg_id, rtr_bit, id_mask, entry_enable
//   out     | out | status, matched, delivered, match_index
//
// program beat: goes to the hold state, which waits for the output register to be free
// receive beat: one entry a cycle until a hit or the last active entry, then the hold state
// busy from accept until the result moves to the output register
// reset clears programmed flags, not the ram; unprogrammed entries read as key 0, mask all ones
// a held result does not block the next beat; a finished result waits for the output register
module can_rx_acceptance_filter_top #(
  parameter int ENTRIES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [caf_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [caf_pkg::EIDX_W-1:0]   entry_index,
  input  logic [caf_pkg::ID_W-1:0]     msg_id,
  input  logic                         rtr_bit,
  input  logic [caf_pkg::ID_W-1:0]     id_mask,
  input  logic                         entry_enable,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic                         matched,
  output logic                         delivered,
  output logic [caf_pkg::MIDX_W-1:0]   match_index
);

  import caf_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t state, state_next;

  logic [CFG_W-1:0]   active_entries;
  logic [ENTRIES-1:0] programmed;
  logic [KEY_W-1:0]   word;
  logic [IDX_W-1:0]   scan_idx;
  res_t               pend;
  res_t               out_res;

  logic [CMP_W-1:0]   eff_cnt;
  logic [CMP_W-1:0]   nxt_cnt;
  logic               prog_ok;
  logic               in_fire;
  logic               out_free;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;
  logic [KEY_W-1:0]   ent_key;
  logic [KEY_W-1:0]   ent_mask;
  logic               hit;
  logic               last;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // active count saturates at the bank size
  assign eff_cnt = ({1'b0, active_entries} > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                              : {1'b0, active_entries};
  assign prog_ok = entry_enable && ({1'b0, entry_index} < eff_cnt);
  assign ram_we  = in_fire && (mode == MODE_PROGRAM) && prog_ok;

  assign nxt_cnt   = CMP_W'(scan_idx) + CMP_W'(1);
  assign ram_raddr = (state == ST_SCAN && nxt_cnt < CMP_W'(ENTRIES)) ? nxt_cnt[IDX_W-1:0]
                                                                     : '0;

  caf_ram #(
    .WIDTH(ENT_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entry_index[IDX_W-1:0]),
    .wdata({id_mask, rtr_bit, msg_id}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared compare unit
  assign ent_key  = programmed[scan_idx] ? ram_rdata[KEY_W-1:0] : '0;
  assign ent_mask = programmed[scan_idx] ? {1'b1, ram_rdata[ENT_W-1:KEY_W]} : FULL_MASK;
  assign hit      = (((word ^ ent_key) & ent_mask) == '0);
  assign last     = (nxt_cnt == eff_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == MODE_PROGRAM || eff_cnt == '0) begin
            state_next = ST_HOLD;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_entries <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      programmed <= '0;
    end else if (ram_we) begin
      programmed[entry_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word     <= {rtr_bit, msg_id};
      scan_idx <= '0;
      pend     <= '{((mode == MODE_PROGRAM) && !prog_ok) ? STATUS_ILL_ARG : STATUS_OK,
                    1'b0, 1'b0, '0};
    end else if (state == ST_SCAN) begin
      if (hit) begin
        pend.matched   <= 1'b1;
        pend.delivered <= programmed[scan_idx];
        pend.idx       <= MIDX_W'(scan_idx);
      end else begin
        scan_idx <= nxt_cnt[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      out_res <= pend;
    end
  end

  assign status      = out_res.status;
  assign matched     = out_res.matched;
  assign delivered   = out_res.delivered;
  assign match_index = out_res.idx;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken while busy");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CMP_W'(scan_idx) < eff_cnt)
    else $error("scan beyond active count");

  a_deliver_needs_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && delivered |-> matched)
    else $error("delivery without match");

  a_status_only_program: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !matched && !delivered && match_index == '0)
    else $error("failed program beat carries match fields");

  a_hold_loads_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_HOLD && out_free |=> out_valid && state == ST_IDLE)
    else $error("result not moved to output register");
`endif

endmodule
